// File: hdl/mnp_pkg.sv
`timescale 1ns / 1ps

package mnp_pkg;

	// field widths of the event and note channels
	localparam int KEY_W  = 7;
	localparam int VEL_W  = 7;
	localparam int TIME_W = 31;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [VEL_W-1:0]  vel_t;
	typedef logic [TIME_W-1:0] tick_t;

	// event command codes
	localparam logic CMD_OFF = 1'b0;
	localparam logic CMD_ON  = 1'b1;

	// result status codes
	localparam logic STATUS_NOTE = 1'b0;
	localparam logic STATUS_DROP = 1'b1;

	// one pending note-on
	typedef struct packed {
		tick_t tick;
		vel_t  vel;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one result item
	typedef struct packed {
		logic  status;
		key_t  key;
		tick_t start;
		tick_t len;
		vel_t  vel;
	} note_t;

	// work handed from the match stage to the finish stage
	typedef struct packed {
		logic  valid;
		logic  drop;
		key_t  key;
		tick_t tick;
		vel_t  vel;
	} s2_t;

	// result queue sizing
	localparam int RES_FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W     = $clog2(RES_FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(RES_FIFO_DEPTH + 1);

endpackage

// File: hdl/mnp_event_if.sv
`timescale 1ns / 1ps

interface mnp_event_if;
	logic              valid;
	logic              ready;
	logic              command;
	mnp_pkg::key_t     key;
	mnp_pkg::vel_t     velocity;
	mnp_pkg::tick_t    tick_time;

	modport source(output valid, command, key, velocity, tick_time, input ready);
	modport sink(input valid, command, key, velocity, tick_time, output ready);
endinterface

// File: hdl/mnp_note_if.sv
`timescale 1ns / 1ps

interface mnp_note_if;
	logic              valid;
	logic              ready;
	logic              status;
	mnp_pkg::key_t     note_key;
	mnp_pkg::tick_t    start_time;
	mnp_pkg::tick_t    note_length;
	mnp_pkg::vel_t     note_velocity;

	modport source(output valid, status, note_key, start_time, note_length, note_velocity,
		input ready);
	modport sink(input valid, status, note_key, start_time, note_length, note_velocity,
		output ready);
endinterface

// File: hdl/mnp_ram.sv
`timescale 1ns / 1ps

module mnp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/mnp_match.sv
`timescale 1ns / 1ps

module mnp_match #(
	parameter int NUM_KEYS    = 128,
	parameter int STACK_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                command,
	input  mnp_pkg::key_t       key,
	input  mnp_pkg::vel_t       velocity,
	input  mnp_pkg::tick_t      tick_time,
	output logic                s1_busy,
	output mnp_pkg::s2_t        s2,
	output mnp_pkg::entry_t     stack_rdata
);

	localparam int KEY_AW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STK_N   = NUM_KEYS * STACK_DEPTH;
	localparam int STK_AW  = (STK_N > 1) ? $clog2(STK_N) : 1;

	// stage 1 registers
	logic            valid_s1;
	logic            cmd_s1;
	mnp_pkg::key_t   key_s1;
	mnp_pkg::vel_t   vel_s1;
	mnp_pkg::tick_t  tick_s1;

	// count tracking
	logic [CNT_W-1:0]  cnt_rdata;
	logic [NUM_KEYS-1:0] cnt_valid_q;
	logic              fwd_valid_q;
	logic [KEY_AW-1:0] fwd_key_q;
	logic [CNT_W-1:0]  fwd_cnt_q;

	logic              key_ok;
	logic [KEY_AW-1:0] kidx;
	logic [CNT_W-1:0]  cnt_cur;
	logic [CNT_W-1:0]  cnt_new;
	logic              is_on;
	logic              push;
	logic              pop;
	logic              drop;
	logic              cnt_we;
	logic [SLOT_W-1:0] slot;
	logic [STK_AW-1:0] stk_addr;
	logic [mnp_pkg::ENTRY_W-1:0] stk_wdata;
	logic [mnp_pkg::ENTRY_W-1:0] stk_rdata_raw;

	// capture the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			key_s1  <= key;
			vel_s1  <= velocity;
			tick_s1 <= tick_time;
		end
	end

	assign s1_busy = valid_s1;

	// count memory, read at the address of the incoming request
	mnp_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_KEYS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(kidx),
		.wdata(cnt_new),
		.raddr(key[KEY_AW-1:0]),
		.rdata(cnt_rdata)
	);

	// current count: newest write wins, unwritten keys read as zero
	always_comb begin
		key_ok = {1'b0, key_s1} < (mnp_pkg::KEY_W + 1)'(NUM_KEYS);
		kidx   = key_s1[KEY_AW-1:0];
		if (fwd_valid_q && (fwd_key_q == kidx)) begin
			cnt_cur = fwd_cnt_q;
		end else if (cnt_valid_q[kidx]) begin
			cnt_cur = cnt_rdata;
		end else begin
			cnt_cur = '0;
		end
	end

	// push, pop or drop decision
	always_comb begin
		is_on  = (cmd_s1 == mnp_pkg::CMD_ON) && (vel_s1 != '0);
		push   = valid_s1 && key_ok && is_on && (cnt_cur != CNT_W'(STACK_DEPTH));
		drop   = valid_s1 && key_ok && is_on && (cnt_cur == CNT_W'(STACK_DEPTH));
		pop    = valid_s1 && key_ok && !is_on && (cnt_cur != '0);
		cnt_we = push || pop;
		cnt_new = push ? (cnt_cur + CNT_W'(1)) : (cnt_cur - CNT_W'(1));
		slot   = push ? SLOT_W'(cnt_cur) : SLOT_W'(cnt_cur - CNT_W'(1));
		stk_addr = STK_AW'(STK_AW'(kidx) * STK_AW'(STACK_DEPTH) + STK_AW'(slot));
		stk_wdata = {tick_s1, vel_s1};
	end

	// count valid flags and write forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
			fwd_valid_q <= 1'b0;
		end else if (cnt_we) begin
			cnt_valid_q[kidx] <= 1'b1;
			fwd_valid_q       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			fwd_key_q <= kidx;
			fwd_cnt_q <= cnt_new;
		end
	end

	// pending note-on memory
	mnp_ram #(
		.WIDTH(mnp_pkg::ENTRY_W),
		.DEPTH(STK_N)
	) u_stack_ram (
		.clk  (clk),
		.we   (push),
		.waddr(stk_addr),
		.wdata(stk_wdata),
		.raddr(stk_addr),
		.rdata(stk_rdata_raw)
	);

	assign stack_rdata = mnp_pkg::entry_t'(stk_rdata_raw);

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else begin
			s2.valid <= pop || drop;
			s2.drop  <= drop;
			s2.key   <= key_s1;
			s2.tick  <= tick_s1;
			s2.vel   <= vel_s1;
		end
	end

endmodule

// File: hdl/mnp_finish.sv
`timescale 1ns / 1ps

module mnp_finish (
	input  mnp_pkg::s2_t    s2,
	input  mnp_pkg::entry_t stack_rdata,
	input  logic            expand,
	output logic            res_valid,
	output mnp_pkg::note_t  res
);

	logic [mnp_pkg::TIME_W:0] diff;
	mnp_pkg::tick_t           len;

	// length of a completed note: clamp below, expand at zero
	always_comb begin
		diff = {1'b0, s2.tick} - {1'b0, stack_rdata.tick};
		if (diff[mnp_pkg::TIME_W]) begin
			len = '0;
		end else if (diff == '0) begin
			len = expand ? mnp_pkg::tick_t'(1) : '0;
		end else begin
			len = diff[mnp_pkg::TIME_W-1:0];
		end
	end

	// assemble the result
	always_comb begin
		res_valid = s2.valid;
		res.key   = s2.key;
		if (s2.drop) begin
			res.status = mnp_pkg::STATUS_DROP;
			res.start  = s2.tick;
			res.len    = '0;
			res.vel    = s2.vel;
		end else begin
			res.status = mnp_pkg::STATUS_NOTE;
			res.start  = stack_rdata.tick;
			res.len    = len;
			res.vel    = stack_rdata.vel;
		end
	end

endmodule

// File: hdl/mnp_res_fifo.sv
`timescale 1ns / 1ps

module mnp_res_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  mnp_pkg::note_t                    din,
	input  logic                              pop,
	output logic                              valid,
	output mnp_pkg::note_t                    dout,
	output logic [mnp_pkg::FIFO_CNT_W-1:0]    count
);

	mnp_pkg::note_t                  mem_q [mnp_pkg::RES_FIFO_DEPTH];
	logic [mnp_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [mnp_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [mnp_pkg::FIFO_CNT_W-1:0]  cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mnp_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mnp_pkg::FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + mnp_pkg::FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - mnp_pkg::FIFO_CNT_W'(1);
			end
		end
	end

	assign valid = cnt_q != '0;
	assign dout  = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

// File: hdl/midi_note_on_off_pairing_top.sv
`timescale 1ns / 1ps

// MIDI note-on / note-off pairing with a LIFO of pending note-ons per key.
// midi:  event requests (command, key, velocity, tick_time), valid/ready.
// notes: result requests (status, note_key, start_time, note_length,
//        note_velocity), valid/ready; a completed note or a dropped note-on.
// cfg_we / cfg_wdata write expand_zero_length; write it only while idle.
// An event is accepted in every cycle while midi.ready is high and uses
// the count and stack memories. A result passes the stage 1 and stage 2
// registers and the result buffer. Events that complete nothing (a push,
// a note-off on an empty key, a key out of range) give no result.
// Results queue in a four-entry buffer; midi.ready drops only when that
// buffer plus the two stages in flight would overflow, so a stalled
// receiver holds the front result steady and throttles the input.
// Reset clears the counts through per-key valid flags, so the block is
// ready as soon as reset is released; expand_zero_length resets to 1.
// Stack entries are undefined until pushed; no result uses one before then.

module midi_note_on_off_pairing_top #(
	parameter int NUM_KEYS    = 128,
	parameter int STACK_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	mnp_event_if.sink          midi,
	mnp_note_if.source         notes
);

	logic                              expand_q;
	logic                              accept;
	logic                              s1_busy;
	mnp_pkg::s2_t                      s2;
	mnp_pkg::entry_t                   stack_rdata;
	logic                              res_valid;
	mnp_pkg::note_t                    res;
	logic                              out_pop;
	logic                              fifo_valid;
	mnp_pkg::note_t                    fifo_dout;
	logic [mnp_pkg::FIFO_CNT_W-1:0]    fifo_cnt;
	logic [mnp_pkg::FIFO_CNT_W-1:0]    in_flight;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expand_q <= 1'b1;
		end else if (cfg_we) begin
			expand_q <= cfg_wdata;
		end
	end

	// accept while the result buffer has room for everything in flight
	always_comb begin
		in_flight  = fifo_cnt + mnp_pkg::FIFO_CNT_W'(s1_busy) + mnp_pkg::FIFO_CNT_W'(s2.valid);
		midi.ready = in_flight < mnp_pkg::FIFO_CNT_W'(mnp_pkg::RES_FIFO_DEPTH);
		accept     = midi.valid && midi.ready;
	end

	mnp_match #(
		.NUM_KEYS   (NUM_KEYS),
		.STACK_DEPTH(STACK_DEPTH)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (midi.command),
		.key        (midi.key),
		.velocity   (midi.velocity),
		.tick_time  (midi.tick_time),
		.s1_busy    (s1_busy),
		.s2         (s2),
		.stack_rdata(stack_rdata)
	);

	mnp_finish u_finish (
		.s2         (s2),
		.stack_rdata(stack_rdata),
		.expand     (expand_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_pop = notes.valid && notes.ready;

	mnp_res_fifo u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.din   (res),
		.pop   (out_pop),
		.valid (fifo_valid),
		.dout  (fifo_dout),
		.count (fifo_cnt)
	);

	// result channel
	always_comb begin
		notes.valid         = fifo_valid;
		notes.status        = fifo_dout.status;
		notes.note_key      = fifo_dout.key;
		notes.start_time    = fifo_dout.start;
		notes.note_length   = fifo_dout.len;
		notes.note_velocity = fifo_dout.vel;
	end

endmodule

// File: hdl/mnp_checker.sv
`timescale 1ns / 1ps

module mnp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic            status,
	input mnp_pkg::key_t   note_key,
	input mnp_pkg::tick_t  start_time,
	input mnp_pkg::tick_t  note_length,
	input mnp_pkg::vel_t   note_velocity
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request withdrawn while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({status, note_key, start_time, note_length, note_velocity}))
		else $error("result payload changed while stalled");

	// input back-pressure only comes from results waiting downstream
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// a dropped note-on carries no length
	a_drop_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mnp_pkg::STATUS_DROP) |-> (note_length == '0))
		else $error("dropped note-on with nonzero length");

	// a completed note always pairs with a real note-on
	a_note_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mnp_pkg::STATUS_NOTE) |-> (note_velocity != '0))
		else $error("completed note with zero velocity");

endmodule

bind midi_note_on_off_pairing_top mnp_checker u_mnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (midi.ready),
	.out_valid    (notes.valid),
	.out_ready    (notes.ready),
	.status       (notes.status),
	.note_key     (notes.note_key),
	.start_time   (notes.start_time),
	.note_length  (notes.note_length),
	.note_velocity(notes.note_velocity)
);
